### design/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared sizes, item types and sequencer states of the least rotation unit.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } lsr_in_t;

  typedef struct packed {
    logic [9:0]  best_start;
    logic [10:0] string_length;
    logic        overflowed;
  } lsr_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } lsr_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } lsr_rd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lsr_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_READ,
    S_CMP,
    S_DONE
  } lsr_state_e;

endpackage

### design/lsr_store.sv
// ----------------------------------------------------------------------------
// lsr_store
// Character buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lsr_store
  import lsr_pkg::*;
(
  input  logic       clk_i,
  input  lsr_wr_t    wr_i,
  input  lsr_rd_t    rd_i,
  output logic [7:0] rdata_a_o,
  output logic [7:0] rdata_b_o
);

  logic [7:0] mem [MAX_LEN];
  logic [7:0] rdata_a_q;
  logic [7:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_a_q <= mem[rd_i.addr_a];
      rdata_b_q <= mem[rd_i.addr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/lsr_seq.sv
// ----------------------------------------------------------------------------
// lsr_seq
// Search sequencer: walks each candidate start against the current best,
// one byte pair per compare step through the shared comparator.
// ----------------------------------------------------------------------------
module lsr_seq
  import lsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [CNT_W-1:0]  len_i,
  input  logic [7:0]        rdata_a_i,
  input  logic [7:0]        rdata_b_i,
  output lsr_rd_t           rd_o,
  output lsr_stat_t         stat_o,
  output logic [ADDR_W-1:0] best_o
);

  lsr_state_e state_q, state_d;

  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [ADDR_W-1:0] pi_q, pi_d;
  logic [ADDR_W-1:0] pb_q, pb_d;
  logic [ADDR_W-1:0] best_q, best_d;

  logic [CNT_W-1:0]  pi_inc;
  logic [CNT_W-1:0]  pb_inc;
  logic [ADDR_W-1:0] pi_wrap;
  logic [ADDR_W-1:0] pb_wrap;
  logic              bytes_eq;
  logic              cand_less;

  // advance both rotation pointers, wrapping at the string length
  assign pi_inc  = CNT_W'(pi_q) + CNT_W'(1);
  assign pb_inc  = CNT_W'(pb_q) + CNT_W'(1);
  assign pi_wrap = (pi_inc >= len_i) ? '0 : ADDR_W'(pi_inc);
  assign pb_wrap = (pb_inc >= len_i) ? '0 : ADDR_W'(pb_inc);

  assign bytes_eq  = (rdata_a_i == rdata_b_i);
  assign cand_less = (rdata_a_i < rdata_b_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = (i_q >= len_i) ? S_DONE : S_READ;
      end
      S_READ: begin
        state_d = (k_q == len_i) ? S_NEXT : S_CMP;
      end
      S_CMP: begin
        state_d = bytes_eq ? S_READ : S_NEXT;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    i_d    = i_q;
    k_d    = k_q;
    pi_d   = pi_q;
    pb_d   = pb_q;
    best_d = best_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          i_d    = CNT_W'(1);
          best_d = '0;
        end
      end
      S_NEXT: begin
        k_d  = '0;
        pi_d = ADDR_W'(i_q);
        pb_d = best_q;
      end
      S_READ: begin
        // full wrap with no difference: drop this candidate
        if (k_q == len_i) i_d = i_q + CNT_W'(1);
      end
      S_CMP: begin
        if (bytes_eq) begin
          k_d  = k_q + CNT_W'(1);
          pi_d = pi_wrap;
          pb_d = pb_wrap;
        end else begin
          if (cand_less) best_d = ADDR_W'(i_q);
          i_d = i_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_o.re     = (state_q == S_READ) && (k_q != len_i);
    rd_o.addr_a = pi_q;
    rd_o.addr_b = pb_q;
    stat_o.busy = (state_q != S_IDLE);
    stat_o.done = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q <= pi_d;
    pb_q <= pb_d;
  end

  assign best_o = best_q;

endmodule

### design/least_string_rotation_unit.sv
// ----------------------------------------------------------------------------
// least_string_rotation_unit
// Buffers a string one byte per word and reports the start of its
// lexicographically least cyclic rotation.
// ----------------------------------------------------------------------------
//  channel   handshake          payload      direction
//  input     start_i / busy_o   in_item_i    in:  one character per word
//  result    done_o (strobe)    res_o        out: one word per string
//
//  A character loads when start_i is high; busy_o stays low while loading.
//  After the last character the search runs with busy_o high: each candidate
//  start is set up in S_NEXT, then each byte pair is read from the buffer in
//  S_READ and compared in S_CMP while the bytes match; when all n pairs match,
//  S_READ returns to S_NEXT. The search finishes through S_DONE.
//  The result shows for one cycle with done_o; the receiver cannot stall.
//  Reset clears the fill count, overflow flag and sequencer, not the buffer.
// ----------------------------------------------------------------------------
module least_string_rotation_unit
  import lsr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  lsr_in_t  in_item_i,
  output logic     busy_o,
  output logic     done_o,
  output lsr_res_t res_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              accept;
  logic              room;
  lsr_wr_t           wr;
  lsr_rd_t           rd;
  lsr_stat_t         stat;
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;
  logic [ADDR_W-1:0] best;

  assign accept = start_i && !stat.busy;
  assign room   = (count_q < CNT_W'(MAX_LEN));

  always_comb begin
    wr.we   = accept && room;
    wr.addr = ADDR_W'(count_q);
    wr.data = in_item_i.char_byte;
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (stat.done) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (accept) begin
      if (room) count_d = count_q + CNT_W'(1);
      else      ovf_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  lsr_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // count_q is stable for the whole search; a full buffer still ends the string
  lsr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept && in_item_i.last_char),
    .len_i     (count_d),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .rd_o      (rd),
    .stat_o    (stat),
    .best_o    (best)
  );

  assign busy_o              = stat.busy;
  assign done_o              = stat.done;
  assign res_o.best_start    = 10'(best);
  assign res_o.string_length = 11'(count_q);
  assign res_o.overflowed    = ovf_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside search");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_char) |=> busy_o)
    else $error("search did not start after last word");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (count_q == '0) && !ovf_q && !done_o)
    else $error("fill state not cleared after result");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_q != '0) && (CNT_W'(best) < count_q))
    else $error("result start outside string");

endmodule
